/* rtl/script_token_lexer_core_assert.svh */
// Assertion macros shared by the lexer RTL.
`ifndef SCRIPT_TOKEN_LEXER_CORE_ASSERT_SVH
`define SCRIPT_TOKEN_LEXER_CORE_ASSERT_SVH

`ifndef SYNTHESIS

`define STLX_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

`define STLX_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`else

`define STLX_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg)

`define STLX_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg)

`endif

`endif

/* rtl/stlx_pkg.sv */
package stlx_pkg;

  localparam int OFFSET_BITS_DEF = 32;
  localparam int LINE_BITS_DEF   = 16;
  localparam int LENGTH_BITS_DEF = 16;

  localparam int KIND_W    = 5;
  localparam int STATUS_W  = 2;
  localparam int OFF_OUT_W = 32;
  localparam int LINE_OUT_W = 16;
  localparam int LEN_OUT_W = 16;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  localparam logic [KIND_W-1:0] KIND_SEMI   = 5'd0;
  localparam logic [KIND_W-1:0] KIND_BAR    = 5'd1;
  localparam logic [KIND_W-1:0] KIND_PLUS   = 5'd2;
  localparam logic [KIND_W-1:0] KIND_BANG   = 5'd3;
  localparam logic [KIND_W-1:0] KIND_MINUS  = 5'd4;
  localparam logic [KIND_W-1:0] KIND_AMP    = 5'd5;
  localparam logic [KIND_W-1:0] KIND_LBRACE = 5'd6;
  localparam logic [KIND_W-1:0] KIND_RBRACE = 5'd7;
  localparam logic [KIND_W-1:0] KIND_LPAREN = 5'd8;
  localparam logic [KIND_W-1:0] KIND_RPAREN = 5'd9;
  localparam logic [KIND_W-1:0] KIND_DOT    = 5'd10;
  localparam logic [KIND_W-1:0] KIND_COLON  = 5'd11;
  localparam logic [KIND_W-1:0] KIND_DIV    = 5'd12;
  localparam logic [KIND_W-1:0] KIND_EQUAL  = 5'd13;
  localparam logic [KIND_W-1:0] KIND_ASSIGN = 5'd14;
  localparam logic [KIND_W-1:0] KIND_STRING = 5'd15;
  localparam logic [KIND_W-1:0] KIND_NUMBER = 5'd16;
  localparam logic [KIND_W-1:0] KIND_NAME   = 5'd17;
  localparam logic [KIND_W-1:0] KIND_END    = 5'd18;
  localparam logic [KIND_W-1:0] KIND_ERROR  = KIND_SEMI;

  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_UNKNOWN = 2'd1;
  localparam logic [STATUS_W-1:0] ST_UNTERM  = 2'd2;

  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_BAR    = 8'h7C;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_BANG   = 8'h21;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_AMP    = 8'h26;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_UNDER  = 8'h5F;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_QUOTE  = 8'h22;

  typedef struct packed {
    logic [7:0] char_byte;
    logic       is_end;
  } stlx_item_t;

  typedef struct packed {
    logic [KIND_W-1:0]     token_kind;
    logic [STATUS_W-1:0]   status;
    logic [OFF_OUT_W-1:0]  start_offset;
    logic [LINE_OUT_W-1:0] line_number;
    logic [LINE_OUT_W-1:0] column_number;
    logic [LEN_OUT_W-1:0]  token_length;
    logic                  last_of_run;
  } stlx_res_t;

  typedef struct packed {
    logic      valid;
    stlx_res_t res;
  } stlx_slot_t;

  typedef struct packed {
    logic              hit;
    logic [KIND_W-1:0] kind;
  } stlx_op_t;

  function automatic logic is_digit(logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_alpha(logic [7:0] c);
    return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
  endfunction

  function automatic logic is_name(logic [7:0] c);
    return is_alpha(c) || is_digit(c) || (c == CH_UNDER);
  endfunction

  function automatic stlx_op_t op_lookup(logic [7:0] c);
    stlx_op_t r;
    r.hit = 1'b1;
    unique case (c)
      CH_SEMI:   r.kind = KIND_SEMI;
      CH_BAR:    r.kind = KIND_BAR;
      CH_PLUS:   r.kind = KIND_PLUS;
      CH_BANG:   r.kind = KIND_BANG;
      CH_MINUS:  r.kind = KIND_MINUS;
      CH_AMP:    r.kind = KIND_AMP;
      CH_LBRACE: r.kind = KIND_LBRACE;
      CH_RBRACE: r.kind = KIND_RBRACE;
      CH_LPAREN: r.kind = KIND_LPAREN;
      CH_RPAREN: r.kind = KIND_RPAREN;
      CH_DOT:    r.kind = KIND_DOT;
      CH_COLON:  r.kind = KIND_COLON;
      default: begin
        r.hit  = 1'b0;
        r.kind = KIND_SEMI;
      end
    endcase
    return r;
  endfunction

endpackage

/* rtl/stlx_in_if.sv */
interface stlx_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_byte;
  logic       is_end;

  modport source (output valid, output char_byte, output is_end, input ready);
  modport sink (input valid, input char_byte, input is_end, output ready);
endinterface

/* rtl/stlx_out_if.sv */
interface stlx_out_if;
  logic                              valid;
  logic                              ready;
  logic [stlx_pkg::KIND_W-1:0]     token_kind;
  logic [stlx_pkg::STATUS_W-1:0]   status;
  logic [stlx_pkg::OFF_OUT_W-1:0]  start_offset;
  logic [stlx_pkg::LINE_OUT_W-1:0] line_number;
  logic [stlx_pkg::LINE_OUT_W-1:0] column_number;
  logic [stlx_pkg::LEN_OUT_W-1:0]  token_length;
  logic                              last_of_run;

  modport source (
    output valid, output token_kind, output status, output start_offset,
    output line_number, output column_number, output token_length,
    output last_of_run, input ready
  );
  modport sink (
    input valid, input token_kind, input status, input start_offset,
    input line_number, input column_number, input token_length,
    input last_of_run, output ready
  );
endinterface

/* rtl/stlx_lexer.sv */
module stlx_lexer #(
  parameter int OFFSET_BITS = stlx_pkg::OFFSET_BITS_DEF,
  parameter int LINE_BITS   = stlx_pkg::LINE_BITS_DEF,
  parameter int LENGTH_BITS = stlx_pkg::LENGTH_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         fire_i,
  input  stlx_pkg::stlx_item_t         item_i,
  output stlx_pkg::stlx_slot_t [1:0]   res_o
);
  import stlx_pkg::*;

  localparam int MODE_W = 4;
  localparam logic [MODE_W-1:0] MODE_IDLE    = 4'd0;
  localparam logic [MODE_W-1:0] MODE_SLASH   = 4'd1;
  localparam logic [MODE_W-1:0] MODE_COMMENT = 4'd2;
  localparam logic [MODE_W-1:0] MODE_STRING  = 4'd3;
  localparam logic [MODE_W-1:0] MODE_EQ      = 4'd4;
  localparam logic [MODE_W-1:0] MODE_NUMBER  = 4'd5;
  localparam logic [MODE_W-1:0] MODE_NAME    = 4'd6;
  localparam logic [MODE_W-1:0] MODE_DONE    = 4'd7;
  localparam logic [MODE_W-1:0] MODE_HALT    = 4'd8;

  logic [MODE_W-1:0]      mode_q, mode_d;
  logic [OFFSET_BITS-1:0] off_q, off_d, soff_q, soff_d;
  logic [LINE_BITS-1:0]   line_q, line_d, col_q, col_d, sline_q, sline_d, scol_q, scol_d;
  logic [LENGTH_BITS-1:0] len_q, len_d;

  logic [7:0]         c;
  stlx_op_t           op;
  stlx_res_t          cur_res, pend_res, a_res, b_res, id_res;
  logic               a_v, b_v, id_v, id_mark, id_len_set, use_idle, do_adv;
  logic [MODE_W-1:0]  id_mode;
  logic [LENGTH_BITS-1:0] id_len, len_inc;

  assign c       = item_i.char_byte;
  assign op      = op_lookup(c);
  assign len_inc = (&len_q) ? len_q : len_q + LENGTH_BITS'(1);

  always_comb begin
    cur_res               = '0;
    cur_res.start_offset  = OFF_OUT_W'(off_q);
    cur_res.line_number   = LINE_OUT_W'(line_q);
    cur_res.column_number = LINE_OUT_W'(col_q);
    cur_res.token_length  = LEN_OUT_W'(1);

    pend_res               = '0;
    pend_res.start_offset  = OFF_OUT_W'(soff_q);
    pend_res.line_number   = LINE_OUT_W'(sline_q);
    pend_res.column_number = LINE_OUT_W'(scol_q);
    pend_res.token_length  = LEN_OUT_W'(len_q);
  end

  // Byte seen between tokens.
  always_comb begin
    id_v       = 1'b0;
    id_res     = cur_res;
    id_mode    = MODE_IDLE;
    id_mark    = 1'b0;
    id_len_set = 1'b0;
    id_len     = '0;
    priority if ((c == CH_SPACE) || (c == CH_NL)) begin
      id_mode = MODE_IDLE;
    end else if (op.hit) begin
      id_v              = 1'b1;
      id_res.token_kind = op.kind;
    end else if (c == CH_SLASH) begin
      id_mark = 1'b1;
      id_mode = MODE_SLASH;
    end else if (c == CH_EQ) begin
      id_mark = 1'b1;
      id_mode = MODE_EQ;
    end else if (c == CH_QUOTE) begin
      id_mark    = 1'b1;
      id_mode    = MODE_STRING;
      id_len_set = 1'b1;
    end else if (is_digit(c)) begin
      id_mark    = 1'b1;
      id_mode    = MODE_NUMBER;
      id_len_set = 1'b1;
      id_len     = LENGTH_BITS'(1);
    end else if (is_alpha(c) || (c == CH_UNDER)) begin
      id_mark    = 1'b1;
      id_mode    = MODE_NAME;
      id_len_set = 1'b1;
      id_len     = LENGTH_BITS'(1);
    end else begin
      id_mark           = 1'b1;
      id_mode           = MODE_HALT;
      id_v              = 1'b1;
      id_res.token_kind = KIND_ERROR;
      id_res.status     = ST_UNKNOWN;
    end
  end

  always_comb begin
    mode_d   = mode_q;
    off_d    = off_q;
    line_d   = line_q;
    col_d    = col_q;
    soff_d   = soff_q;
    sline_d  = sline_q;
    scol_d   = scol_q;
    len_d    = len_q;
    a_v      = 1'b0;
    a_res    = pend_res;
    b_v      = 1'b0;
    b_res    = cur_res;
    use_idle = 1'b0;
    do_adv   = 1'b0;

    if (fire_i && (mode_q != MODE_HALT)) begin
      if (item_i.is_end) begin
        b_res.token_kind   = KIND_END;
        b_res.token_length = '0;
        unique case (mode_q)
          MODE_NUMBER: begin
            a_v              = 1'b1;
            a_res.token_kind = KIND_NUMBER;
          end
          MODE_NAME: begin
            a_v              = 1'b1;
            a_res.token_kind = KIND_NAME;
          end
          MODE_SLASH: begin
            len_d              = LENGTH_BITS'(1);
            a_v                = 1'b1;
            a_res.token_kind   = KIND_DIV;
            a_res.token_length = LEN_OUT_W'(1);
          end
          MODE_EQ: begin
            len_d              = LENGTH_BITS'(1);
            a_v                = 1'b1;
            a_res.token_kind   = KIND_ASSIGN;
            a_res.token_length = LEN_OUT_W'(1);
          end
          MODE_STRING: begin
            a_v              = 1'b1;
            a_res.token_kind = KIND_ERROR;
            a_res.status     = ST_UNTERM;
            mode_d           = MODE_HALT;
          end
          default: begin
          end
        endcase
        if (mode_q != MODE_STRING) begin
          b_v    = 1'b1;
          mode_d = MODE_DONE;
        end
      end else begin
        do_adv = 1'b1;
        unique case (mode_q)
          MODE_DONE: begin
            do_adv = 1'b0;
          end
          MODE_COMMENT: begin
            if (c == CH_NL) begin
              mode_d = MODE_IDLE;
            end
          end
          MODE_STRING: begin
            if (c == CH_QUOTE) begin
              a_v              = 1'b1;
              a_res.token_kind = KIND_STRING;
              mode_d           = MODE_IDLE;
            end else begin
              len_d = len_inc;
            end
          end
          MODE_SLASH: begin
            if (c == CH_SLASH) begin
              mode_d = MODE_COMMENT;
            end else begin
              len_d              = LENGTH_BITS'(1);
              a_v                = 1'b1;
              a_res.token_kind   = KIND_DIV;
              a_res.token_length = LEN_OUT_W'(1);
              use_idle           = 1'b1;
            end
          end
          MODE_EQ: begin
            a_v = 1'b1;
            if (c == CH_EQ) begin
              len_d              = LENGTH_BITS'(2);
              a_res.token_kind   = KIND_EQUAL;
              a_res.token_length = LEN_OUT_W'(2);
              mode_d             = MODE_IDLE;
            end else begin
              len_d              = LENGTH_BITS'(1);
              a_res.token_kind   = KIND_ASSIGN;
              a_res.token_length = LEN_OUT_W'(1);
              use_idle           = 1'b1;
            end
          end
          MODE_NUMBER: begin
            if (is_digit(c)) begin
              len_d = len_inc;
            end else begin
              a_v              = 1'b1;
              a_res.token_kind = KIND_NUMBER;
              use_idle         = 1'b1;
            end
          end
          MODE_NAME: begin
            if (is_name(c)) begin
              len_d = len_inc;
            end else begin
              a_v              = 1'b1;
              a_res.token_kind = KIND_NAME;
              use_idle         = 1'b1;
            end
          end
          default: begin
            use_idle = 1'b1;
          end
        endcase

        if (use_idle) begin
          mode_d = id_mode;
          b_v    = id_v;
          b_res  = id_res;
          if (id_mark) begin
            soff_d  = off_q;
            sline_d = line_q;
            scol_d  = col_q;
          end
          if (id_len_set) begin
            len_d = id_len;
          end
        end

        if (do_adv && (mode_d != MODE_HALT)) begin
          off_d = (&off_q) ? off_q : off_q + OFFSET_BITS'(1);
          if (c == CH_NL) begin
            line_d = (&line_q) ? line_q : line_q + LINE_BITS'(1);
            col_d  = '0;
          end else begin
            col_d = (&col_q) ? col_q : col_q + LINE_BITS'(1);
          end
        end
      end
    end
  end

  // Pack the pending-token result ahead of the current-byte result.
  always_comb begin
    res_o[0].valid           = a_v | b_v;
    res_o[0].res             = a_v ? a_res : b_res;
    res_o[0].res.last_of_run = ~(a_v & b_v);
    res_o[1].valid           = a_v & b_v;
    res_o[1].res             = b_res;
    res_o[1].res.last_of_run = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_IDLE;
      off_q   <= '0;
      line_q  <= '0;
      col_q   <= '0;
      soff_q  <= '0;
      sline_q <= '0;
      scol_q  <= '0;
      len_q   <= '0;
    end else begin
      mode_q  <= mode_d;
      off_q   <= off_d;
      line_q  <= line_d;
      col_q   <= col_d;
      soff_q  <= soff_d;
      sline_q <= sline_d;
      scol_q  <= scol_d;
      len_q   <= len_d;
    end
  end

`include "script_token_lexer_core_assert.svh"

  `STLX_ASSERT_NXT(a_halt_sticky, clk_i, rst_ni, mode_q == MODE_HALT, mode_q == MODE_HALT, "Lexer left the halted mode.")
  `STLX_ASSERT_NXT(a_done_sticky, clk_i, rst_ni, mode_q == MODE_DONE, mode_q == MODE_DONE, "Lexer left the done mode.")
  `STLX_ASSERT_NXT(a_done_frozen, clk_i, rst_ni, mode_q == MODE_DONE, $stable(off_q), "Offset moved after the end token.")

endmodule

/* rtl/stlx_res_fifo.sv */
module stlx_res_fifo (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  stlx_pkg::stlx_slot_t [1:0] push_i,
  output logic                       space_o,
  output logic                       valid_o,
  input  logic                       ready_i,
  output stlx_pkg::stlx_res_t        head_o
);
  import stlx_pkg::*;

  stlx_res_t               mem_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0]   wr_q, rd_q;
  logic [FIFO_CNT_W-1:0]   cnt_q, cnt_d;
  logic [FIFO_PTR_W-1:0]   wr_next;
  logic [FIFO_PTR_W-1:0]   push_n;
  logic                    pop;

  assign pop     = valid_o & ready_i;
  assign valid_o = (cnt_q != '0);
  assign head_o  = mem_q[rd_q];
  assign space_o = (cnt_q <= FIFO_CNT_W'(FIFO_DEPTH - 2));
  assign push_n  = FIFO_PTR_W'(push_i[0].valid) + FIFO_PTR_W'(push_i[1].valid);
  assign wr_next = wr_q + FIFO_PTR_W'(1);
  assign cnt_d   = cnt_q + FIFO_CNT_W'(push_n) - FIFO_CNT_W'(pop);

  always_ff @(posedge clk_i) begin
    if (push_i[0].valid) begin
      mem_q[wr_q] <= push_i[0].res;
    end
    if (push_i[1].valid) begin
      mem_q[wr_next] <= push_i[1].res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_q + push_n;
      rd_q  <= rd_q + FIFO_PTR_W'(pop);
      cnt_q <= cnt_d;
    end
  end

`include "script_token_lexer_core_assert.svh"

  `STLX_ASSERT_IMP(a_cnt_bound, clk_i, rst_ni, 1'b1, cnt_q <= FIFO_CNT_W'(FIFO_DEPTH), "Result queue count out of range.")
  `STLX_ASSERT_IMP(a_push_room, clk_i, rst_ni, push_i[0].valid, space_o, "Result pushed without room for two.")
  `STLX_ASSERT_IMP(a_pair_order, clk_i, rst_ni, push_i[1].valid, push_i[0].valid, "Second result pushed without the first.")

endmodule

/* rtl/script_token_lexer_core.sv */
// Script token lexer. Takes one source byte, or an end marker, per input transaction and
// returns tokens (kind, status, start offset, line, column, length) on the output channel.
// The input is registered and the lexer state updates from the registered byte, so one
// byte is consumed per clock while the result queue has room. Each byte gives zero, one or
// two results; they enter a four-entry result queue that drains one result per clock while
// the output is ready, and the input stalls only while that queue has fewer than two free
// entries. A byte is first held in the input register; its results are then written into
// the result queue, whose head drives the output channel.
// After an error result the block consumes input silently until reset.
module script_token_lexer_core #(
  parameter int OFFSET_BITS = stlx_pkg::OFFSET_BITS_DEF,
  parameter int LINE_BITS   = stlx_pkg::LINE_BITS_DEF,
  parameter int LENGTH_BITS = stlx_pkg::LENGTH_BITS_DEF
) (
  input logic       clk_i,
  input logic       rst_ni,
  stlx_in_if.sink   in_i,
  stlx_out_if.source out_o
);
  import stlx_pkg::*;

  logic             in_vld_q;
  stlx_item_t       item_q;
  logic             in_ready;
  logic             fire;
  logic             space;
  stlx_slot_t [1:0] slots;
  stlx_res_t        head;
  logic             out_valid;

  assign fire       = in_vld_q & space;
  assign in_ready   = ~in_vld_q | fire;
  assign in_i.ready = in_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready) begin
      in_vld_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_ready) begin
      item_q.char_byte <= in_i.char_byte;
      item_q.is_end    <= in_i.is_end;
    end
  end

  stlx_lexer #(
    .OFFSET_BITS (OFFSET_BITS),
    .LINE_BITS   (LINE_BITS),
    .LENGTH_BITS (LENGTH_BITS)
  ) u_lexer (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .item_i (item_q),
    .res_o  (slots)
  );

  stlx_res_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (slots),
    .space_o (space),
    .valid_o (out_valid),
    .ready_i (out_o.ready),
    .head_o  (head)
  );

  assign out_o.valid         = out_valid;
  assign out_o.token_kind    = head.token_kind;
  assign out_o.status        = head.status;
  assign out_o.start_offset  = head.start_offset;
  assign out_o.line_number   = head.line_number;
  assign out_o.column_number = head.column_number;
  assign out_o.token_length  = head.token_length;
  assign out_o.last_of_run   = head.last_of_run;

endmodule
